// ===== rtl/ssc_pkg.sv =====
// Shared types, constants and helpers for the substring search block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

   localparam int PATTERN_MAX_DEF = 32;
   localparam int TEXT_MAX_DEF    = 65536;
   localparam int POS_W           = 16;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] FOLD_DELTA   = 8'h20;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   typedef enum logic [0:0] {
      ST_SCAN = 1'b0,
      ST_LOAD = 1'b1
   } ssc_state_type;

   typedef struct packed {
      logic pat_start;
      logic pat_write;
      logic pat_over;
      logic scan_clear;
      logic text_step;
      logic text_last;
   } ssc_cmd_type;

   typedef struct packed {
      logic pat_full;
   } ssc_stat_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic case_sens);
      logic [7:0] r;
      r = c;
      if (!case_sens && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + FOLD_DELTA;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ssc_req_if.sv =====
// Request channel interface: valid/ready plus one input item.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface ssc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output kind, output data_byte, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssc_rsp_if.sv =====
// Response channel interface: valid/ready plus one result item.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface ssc_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [15:0] position;
   logic        pattern_overflow;

   modport source (output valid, output found, output position, output pattern_overflow,
                   input ready);
   modport sink   (input valid, input found, input position, input pattern_overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/substring_search_case_fold_top.sv =====
// A result is valid in the cycle after the transfer of the last text byte.
// Throughput: one pattern or text byte per cycle; every lane of the window is
// compared against the stored pattern in the same cycle the byte is taken.
// Input is held off only while a finished result waits and rsp is not ready.
// Reset (synchronous, active high): empty complete pattern, scan cleared,
// exact byte compare selected, no result pending. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module substring_search_case_fold_top #(
   parameter int PATTERN_MAX = ssc_pkg::PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = ssc_pkg::TEXT_MAX_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_write_enable,
   input  wire        csr_write_data,
   ssc_req_if.sink    req_if,
   ssc_rsp_if.source  rsp_if
);
   import ssc_pkg::*;

   // command/status bundle between the controller and the datapath
   ssc_cmd_type  cmd;
   ssc_stat_type stat;

   // Controller: tracks whether a pattern load is open, decides per transfer
   // whether a pattern byte is stored or dropped as overflow, and owns the
   // response valid flop that parts the two channels.
   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: pattern shift line (newest pattern byte at lane 0), text window
   // shift line, one compare per lane, saturating text count and the
   // first-match offset. Result fields are registered on the last text byte.
   ssc_dpath #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_data_byte        (req_if.data_byte),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_found            (rsp_if.found),
      .rsp_position         (rsp_if.position),
      .rsp_pattern_overflow (rsp_if.pattern_overflow)
   );

endmodule

`default_nettype wire

// ===== rtl/ssc_ctrl.sv =====
// Controller: pattern-load state machine, handshake and response valid.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_kind,
   input  wire                  req_last,
   output logic                 req_ready,
   input  wire                  rsp_ready,
   output logic                 rsp_valid,
   input  ssc_pkg::ssc_stat_type stat,
   output ssc_pkg::ssc_cmd_type  cmd
);
   import ssc_pkg::*;

   ssc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         unique case (req_kind)
            KIND_PATTERN: begin
               // first byte after a complete pattern starts a new one
               cmd.pat_start  = (state_ff == ST_SCAN);
               cmd.pat_write  = cmd.pat_start || !stat.pat_full;
               cmd.pat_over   = !cmd.pat_write;
               cmd.scan_clear = 1'b1;
               state_in       = req_last ? ST_SCAN : ST_LOAD;
            end
            KIND_TEXT: begin
               cmd.text_step = 1'b1;
               cmd.text_last = req_last;
               state_in      = ST_SCAN;
               if (req_last) begin
                  rsp_valid_in = 1'b1;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ssc_dpath.sv =====
// Datapath: pattern and text shift lines, per-lane compare, scan state, result regs.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_dpath #(
   parameter int PATTERN_MAX = ssc_pkg::PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = ssc_pkg::TEXT_MAX_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_write_enable,
   input  wire                        csr_write_data,
   input  wire  [7:0]                 req_data_byte,
   input  ssc_pkg::ssc_cmd_type       cmd,
   output ssc_pkg::ssc_stat_type      stat,
   output logic                       rsp_found,
   output logic [ssc_pkg::POS_W-1:0]  rsp_position,
   output logic                       rsp_pattern_overflow
);
   import ssc_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CNT_W = $clog2(TEXT_MAX + 2);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TEXT_MAX);

   // pat_ff[0] holds the last pattern byte, pat_ff[i] the byte i places earlier
   logic [7:0]       pat_ff [PATTERN_MAX];
   logic [7:0]       win_ff [PATTERN_MAX];
   logic [7:0]       win_next [PATTERN_MAX];
   logic [LEN_W-1:0] len_ff;
   logic             ovf_ff;
   logic             cs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             seen_ff, seen_in;
   logic [POS_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0] off_wide;
   logic [PATTERN_MAX-1:0] lane_ok;
   logic             window_hit;
   logic             result_found;

   assign stat.pat_full = (len_ff == LEN_FULL);

   // newest text byte enters lane 0
   always_comb begin
      win_next[0] = req_data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_next[i] = win_ff[i-1];
      end
   end

   // lanes past the pattern length always pass
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         lane_ok[i] = (LEN_W'(i) >= len_ff) ||
                      (fold_byte(pat_ff[i], cs_ff) == fold_byte(win_next[i], cs_ff));
      end
   end
   assign window_hit = &lane_ok;

   always_comb begin
      cnt_in   = (cnt_ff <= CNT_LIMIT) ? cnt_ff + CNT_W'(1) : cnt_ff;
      seen_in  = seen_ff;
      off_in   = off_ff;
      off_wide = cnt_in - CNT_W'(len_ff);
      if (!seen_ff && cnt_in <= CNT_LIMIT) begin
         priority if (len_ff == '0) begin
            seen_in = 1'b1;
            off_in  = '0;
         end else if (cnt_in >= CNT_W'(len_ff) && window_hit &&
                      (off_wide >> POS_W) == '0) begin
            seen_in = 1'b1;
            off_in  = POS_W'(off_wide);
         end else begin
            seen_in = seen_ff;
         end
      end
      result_found = seen_in && (cnt_in <= CNT_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff   <= 1'b1;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= '0;
         seen_ff <= 1'b0;
         off_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            cs_ff <= csr_write_data;
         end
         if (cmd.pat_write) begin
            len_ff <= cmd.pat_start ? LEN_W'(1) : len_ff + LEN_W'(1);
         end
         if (cmd.pat_start) begin
            ovf_ff <= 1'b0;
         end else if (cmd.pat_over) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.scan_clear || (cmd.text_step && cmd.text_last)) begin
            cnt_ff  <= '0;
            seen_ff <= 1'b0;
            off_ff  <= '0;
         end else if (cmd.text_step) begin
            cnt_ff  <= cnt_in;
            seen_ff <= seen_in;
            off_ff  <= off_in;
         end
      end
   end

   // shift lines and result payload carry no reset
   always_ff @(posedge clock) begin
      if (cmd.pat_write) begin
         pat_ff[0] <= req_data_byte;
         for (int i = 1; i < PATTERN_MAX; i++) begin
            pat_ff[i] <= pat_ff[i-1];
         end
      end
      if (cmd.text_step) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_ff[i] <= win_next[i];
         end
      end
      if (cmd.text_step && cmd.text_last) begin
         rsp_found            <= result_found;
         rsp_position         <= result_found ? off_in : '0;
         rsp_pattern_overflow <= ovf_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ssc_checker.sv =====
// Port-level checks for the substring search top level, attached by bind.
// Depends on substring_search_case_fold_top and its interfaces.
`timescale 1ns / 1ps
`default_nettype none

module ssc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_kind,
   input wire        req_last,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        rsp_found,
   input wire [15:0] rsp_position
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a new result only follows the last text byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_kind && req_last))
      else $error("result without a last text transfer");

   // no match means offset zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == 16'd0)
      else $error("nonzero position without a match");

   // input is held off only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a pending result");

endmodule

bind substring_search_case_fold_top ssc_checker u_ssc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_kind     (req_if.kind),
   .req_last     (req_if.last),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_found    (rsp_if.found),
   .rsp_position (rsp_if.position)
);

`default_nettype wire
